// ===== hdl/vshs_pkg.sv =====
// Package for the visited-state hash set: sizes, register codes, hash constants,
// the queue record between front and back, and register clamping functions.
// No dependencies.
package vshs_pkg;

  localparam int VAR_W     = 32;
  localparam int MAX_VARS  = 32;
  localparam int IDX_W     = 5;
  localparam int CNT_W     = 6;
  localparam int ENTRIES   = 4096;
  localparam int ENT_W     = 12;
  localparam int LINK_W    = 13;
  localparam int POWER_MAX = 12;
  localparam int BKT_W     = 12;
  localparam int VADDR_W   = ENT_W + IDX_W;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;

  // Golden-ratio multiplier split into 32-bit halves
  localparam logic [31:0] GOLD_HI = 32'h9e3779b9;
  localparam logic [31:0] GOLD_LO = 32'h7f4a8000;

  localparam logic [3:0] POWER_RESET = 4'd9;
  localparam logic [5:0] NVARS_RESET = 6'd32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HASH_POWER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_VARS   = 1'b1;

  // One accepted variable, classified by the front
  typedef struct packed {
    logic [VAR_W-1:0]    value;
    logic [IDX_W-1:0]    idx;
    logic                kept;
    logic                last;
    logic                lerr;
    logic [MAX_VARS-1:0] word;
  } rec_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  function automatic logic [3:0] eff_power(input logic [3:0] p);
    if (p < 4'd1) return 4'd1;
    if (p > 4'(POWER_MAX)) return 4'(POWER_MAX);
    return p;
  endfunction

  function automatic logic [5:0] eff_vars(input logic [5:0] v);
    if (v < 6'd1) return 6'd1;
    if (v > 6'(MAX_VARS)) return 6'(MAX_VARS);
    return v;
  endfunction

endpackage

// ===== hdl/vshs_if.sv =====
// Channel interfaces of the visited-state hash set: variable items in,
// lookup results out. Depends on vshs_pkg.
interface vshs_item_if import vshs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAR_W-1:0] var_value;
  logic                    last_var;
  modport source (output valid, var_value, last_var, input ready);
  modport sink (input valid, var_value, last_var, output ready);
endinterface

interface vshs_result_if import vshs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_new;
  logic              table_full;
  logic              length_error;
  logic [BKT_W-1:0]  bucket_index;
  logic [LINK_W-1:0] stored_count;
  modport source (output valid, is_new, table_full, length_error, bucket_index,
                  stored_count, input ready);
  modport sink (input valid, is_new, table_full, length_error, bucket_index,
                stored_count, output ready);
endinterface

// ===== hdl/vshs_front.sv =====
// Front of the hash set: counts variables, folds parities, checks length and
// pushes one record per accepted item. Depends on vshs_pkg, vshs_if.
module vshs_front import vshs_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic [5:0]     num_vars,
  input  logic           clearing,
  input  q_stat_t        q_stat,
  vshs_item_if.sink      item,
  output logic           push,
  output rec_t           push_rec
);

  logic [CNT_W-1:0]    var_cnt;
  logic [MAX_VARS-1:0] fold;
  logic [CNT_W-1:0]    total;
  logic [MAX_VARS-1:0] fold_next;

  assign item.ready = !q_stat.full && !clearing;
  assign push       = item.valid && item.ready;

  // Saturate the count one past the largest vector
  assign total     = (var_cnt < CNT_W'(MAX_VARS + 1)) ? var_cnt + 1'b1 : var_cnt;
  assign fold_next = {fold[MAX_VARS-2:0], item.var_value[0]};

  always_comb begin
    push_rec.value = item.var_value;
    push_rec.idx   = var_cnt[IDX_W-1:0];
    push_rec.kept  = (var_cnt < CNT_W'(MAX_VARS));
    push_rec.last  = item.last_var;
    push_rec.lerr  = (total != eff_vars(num_vars));
    push_rec.word  = fold_next;
  end

  // Advance the count, restart on the closing variable
  always_ff @(posedge clk) begin
    if (rst) begin
      var_cnt <= '0;
      fold    <= '0;
    end else if (push) begin
      if (item.last_var) begin
        var_cnt <= '0;
        fold    <= '0;
      end else begin
        var_cnt <= total;
        fold    <= fold_next;
      end
    end
  end

endmodule

// ===== hdl/vshs_queue.sv =====
// Two-entry record queue between front and back.
// Depends on vshs_pkg.
module vshs_queue import vshs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  rec_t    push_rec,
  input  logic    pop,
  output rec_t    pop_rec,
  output q_stat_t q_stat
);

  rec_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign pop_rec      = slots[rd_ptr];
  assign q_stat.valid = (fill != 2'd0);
  assign q_stat.full  = (fill == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  // Move pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hdl/vshs_back.sv =====
// Back of the hash set: stages variables, hashes, walks the bucket chain,
// inserts and reports. Holds all table memories. Depends on vshs_pkg, vshs_if.
module vshs_back import vshs_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic [3:0]    hash_power,
  input  logic [5:0]    num_vars,
  input  q_stat_t       q_stat,
  input  rec_t          q_rec,
  output logic          pop,
  output logic          clearing,
  vshs_result_if.source result
);

  typedef enum logic [13:0] {
    S_CLEAR    = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_HASH_LO  = 14'b00000000000100,
    S_HASH_HI  = 14'b00000000001000,
    S_HEAD_RD  = 14'b00000000010000,
    S_HEAD_CHK = 14'b00000000100000,
    S_CMP_RD   = 14'b00000001000000,
    S_CMP_CHK  = 14'b00000010000000,
    S_NEXT_RD  = 14'b00000100000000,
    S_NEXT_CHK = 14'b00001000000000,
    S_INS_RD   = 14'b00010000000000,
    S_INS_WR   = 14'b00100000000000,
    S_LINK     = 14'b01000000000000,
    S_REPORT   = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  // Table memories
  logic [LINK_W-1:0] head_mem  [ENTRIES];
  logic [LINK_W-1:0] next_mem  [ENTRIES];
  logic [VAR_W-1:0]  vars_mem  [ENTRIES*MAX_VARS];
  logic [VAR_W-1:0]  stage_mem [MAX_VARS];

  logic [LINK_W-1:0] head_rd, next_rd;
  logic [VAR_W-1:0]  vars_rd, stg_rd;

  logic [ENT_W-1:0]    clr_addr;
  logic [MAX_VARS-1:0] word;
  logic [63:0]         prod_lo;
  logic [BKT_W-1:0]    bucket;
  logic [LINK_W-1:0]   head_q;
  logic [LINK_W-1:0]   link;
  logic [IDX_W-1:0]    idx;
  logic [LINK_W-1:0]   count;
  logic                res_new, res_full, res_lerr;

  logic [ENT_W-1:0]  link_m1;
  logic [5:0]        n;
  logic [3:0]        pw;
  logic [63:0]       prod_hi;
  logic [31:0]       top;
  logic [BKT_W-1:0]  bucket_calc;
  logic              last_idx;
  logic              out_free;

  assign link_m1     = ENT_W'(link - 1'b1);
  assign n           = eff_vars(num_vars);
  assign pw          = eff_power(hash_power);
  assign prod_hi     = 64'(word) * 64'(GOLD_HI);
  assign top         = prod_lo[63:32] + prod_hi[31:0];
  assign bucket_calc = top[31:32-BKT_W] >> (4'(POWER_MAX) - pw);
  assign last_idx    = (idx == IDX_W'(n - 6'd1));
  assign out_free    = !result.valid || result.ready;
  assign clearing    = (state == S_CLEAR);
  assign pop         = (state == S_IDLE) && q_stat.valid;

  // Memory ports: registered reads, single write each
  always_ff @(posedge clk) begin
    head_rd <= head_mem[bucket];
    if (state == S_CLEAR) head_mem[clr_addr] <= '0;
    else if (state == S_LINK) head_mem[bucket] <= count + 1'b1;
  end

  always_ff @(posedge clk) begin
    next_rd <= next_mem[link_m1];
    if (state == S_LINK) next_mem[count[ENT_W-1:0]] <= head_q;
  end

  always_ff @(posedge clk) begin
    vars_rd <= vars_mem[{link_m1, idx}];
    if (state == S_INS_WR) begin
      vars_mem[{count[ENT_W-1:0], idx}] <= (6'(idx) < n) ? stg_rd : '0;
    end
  end

  always_ff @(posedge clk) begin
    stg_rd <= stage_mem[idx];
    if (pop && q_rec.kept) stage_mem[q_rec.idx] <= q_rec.value;
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:    if (&clr_addr) state_next = S_IDLE;
      S_IDLE: begin
        if (pop && q_rec.last) state_next = q_rec.lerr ? S_REPORT : S_HASH_LO;
      end
      S_HASH_LO:  state_next = S_HASH_HI;
      S_HASH_HI:  state_next = S_HEAD_RD;
      S_HEAD_RD:  state_next = S_HEAD_CHK;
      S_HEAD_CHK: begin
        if (head_rd != '0) state_next = S_CMP_RD;
        else state_next = count[LINK_W-1] ? S_REPORT : S_INS_RD;
      end
      S_CMP_RD:   state_next = S_CMP_CHK;
      S_CMP_CHK: begin
        if (vars_rd != stg_rd) state_next = S_NEXT_RD;
        else if (last_idx) state_next = S_REPORT;
        else state_next = S_CMP_RD;
      end
      S_NEXT_RD:  state_next = S_NEXT_CHK;
      S_NEXT_CHK: begin
        if (next_rd != '0) state_next = S_CMP_RD;
        else state_next = count[LINK_W-1] ? S_REPORT : S_INS_RD;
      end
      S_INS_RD:   state_next = S_INS_WR;
      S_INS_WR:   state_next = (&idx) ? S_LINK : S_INS_RD;
      S_LINK:     state_next = S_REPORT;
      S_REPORT:   if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      count    <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == S_LINK) count <= count + 1'b1;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        word     <= q_rec.word;
        bucket   <= '0;
        res_lerr <= q_rec.lerr;
        res_new  <= 1'b0;
        res_full <= 1'b0;
      end
      S_HASH_LO: prod_lo <= 64'(word) * 64'(GOLD_LO);
      S_HASH_HI: bucket <= bucket_calc;
      S_HEAD_CHK: begin
        head_q <= head_rd;
        link   <= head_rd;
        idx    <= '0;
        if (head_rd == '0) res_full <= count[LINK_W-1];
      end
      S_CMP_CHK: begin
        if (vars_rd != stg_rd) idx <= '0;
        else if (!last_idx) idx <= idx + 1'b1;
      end
      S_NEXT_CHK: begin
        link <= next_rd;
        if (next_rd == '0) res_full <= count[LINK_W-1];
      end
      S_INS_WR:  idx <= idx + 1'b1;
      S_LINK:    res_new <= 1'b1;
      default: ;
    endcase
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == S_REPORT && out_free) begin
      result.valid        <= 1'b1;
      result.is_new       <= res_new;
      result.table_full   <= res_full;
      result.length_error <= res_lerr;
      result.bucket_index <= bucket;
      result.stored_count <= count;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/visited_state_hash_set.sv =====
// Top level of the visited-state hash set: configuration registers, front,
// queue and back. Depends on vshs_pkg, vshs_if, vshs_front, vshs_queue, vshs_back.
//
//   port     dir  request
//   item     in   one state variable, last_var closes the vector
//   result   out  one lookup outcome per closed vector
//   cfg_*    in   register write, no handshake
//
// A closing variable is hashed, its bucket chain is walked, comparing the stored
// variables of each entry visited and following its links, and it is inserted
// when not found and room is left; a length error goes straight to the report.
// The back's single chain walker takes no new variable until its report is issued.
// After reset a pass clears the bucket heads; items wait meanwhile.
// A stalled result holds the back, the two-entry queue then stalls the front.
module visited_state_hash_set import vshs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  vshs_item_if.sink            item,
  vshs_result_if.source        result
);

  logic [3:0] hash_power;
  logic [5:0] num_vars;
  logic       clearing;
  logic       push, pop;
  rec_t       push_rec, pop_rec;
  q_stat_t    q_stat;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_power <= POWER_RESET;
      num_vars   <= NVARS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HASH_POWER: hash_power <= cfg_data[3:0];
        REG_NUM_VARS:   num_vars   <= cfg_data;
        default: ;
      endcase
    end
  end

  vshs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .num_vars (num_vars),
    .clearing (clearing),
    .q_stat   (q_stat),
    .item     (item),
    .push     (push),
    .push_rec (push_rec)
  );

  vshs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .q_stat   (q_stat)
  );

  vshs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .hash_power (hash_power),
    .num_vars   (num_vars),
    .q_stat     (q_stat),
    .q_rec      (pop_rec),
    .pop        (pop),
    .clearing   (clearing),
    .result     (result)
  );

  // No items taken while the heads are being cleared
  a_no_item_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !item.ready) else $error("item accepted during clear");

  // Queue never overflows or underflows
  a_queue_bounds: assert property (@(posedge clk) disable iff (rst)
    (push |-> !q_stat.full) and (pop |-> q_stat.valid))
    else $error("queue bound violated");

  // A length error reports bucket zero and no insert
  a_lerr_result: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.length_error) |->
      (result.bucket_index == '0 && !result.is_new && !result.table_full))
    else $error("bad length-error result");

  // Insert and full are exclusive
  a_new_full: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.is_new && result.table_full))
    else $error("is_new with table_full");

endmodule
